// ===== src/epoch_seconds_calendar_convert_macros.svh =====
// ----------------------------------------------------------------------------
// epoch seconds calendar converter assertion macros
// shared property shorthands for the converter's checks
// ----------------------------------------------------------------------------
`ifndef EPOCH_SECONDS_CALENDAR_CONVERT_MACROS_SVH
`define EPOCH_SECONDS_CALENDAR_CONVERT_MACROS_SVH

// same-cycle implication
`define ESCC_ASSERT_NOW(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ESCC_ASSERT_NEXT(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/escc_pkg.sv =====
// ----------------------------------------------------------------------------
// escc_pkg
// types, constants and calendar helpers for the epoch seconds converter
// ----------------------------------------------------------------------------
`default_nettype none

package escc_pkg;

  localparam int DATA_W = 72;

  localparam logic [11:0] EPOCH_YEAR   = 12'd1970;
  localparam logic [31:0] SECS_PER_DAY = 32'd86400;
  localparam logic [11:0] SECS_PER_HR  = 12'd3600;
  localparam logic [5:0]  SECS_PER_MIN = 6'd60;
  localparam logic [3:0]  LAST_MONTH   = 4'd12;
  localparam logic [3:0]  MONTH_CAP    = 4'd13;

  // reciprocals for the split: x / 675 as (x * DAY_RECIP) >> 35,
  // x / 225 as (x * HOUR_RECIP) >> 21, x / 15 as (x * MIN_RECIP) >> 14
  localparam logic [25:0] DAY_RECIP  = 26'd50903317;
  localparam logic [13:0] HOUR_RECIP = 14'd9321;
  localparam logic [10:0] MIN_RECIP  = 11'd1093;

  localparam logic [4:0] MONTH_LEN [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV_DAY,
    S_INIT_HOUR,
    S_DIV_HOUR,
    S_INIT_MIN,
    S_DIV_MIN,
    S_SPLIT_END,
    S_YEAR,
    S_MONTH,
    S_MUL,
    S_SUM,
    S_FINISH
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_DIV_DAY,
    OP_HOUR_INIT,
    OP_DIV_HOUR,
    OP_MIN_INIT,
    OP_DIV_MIN,
    OP_SPLIT_END,
    OP_YEAR_STEP,
    OP_MON_STEP,
    OP_MUL,
    OP_SUM,
    OP_FINISH
  } dp_op_t;

  typedef struct packed {
    logic req_date;
    logic year_more;
    logic mon_more;
  } dp_status_t;

  // gregorian leap test, y / 100 by reciprocal with one correction
  function automatic logic is_leap(input logic [11:0] y);
    logic [17:0] prod;
    logic [5:0]  q;
    logic [12:0] r;
    logic [5:0]  qc;
    logic [12:0] rc;
    prod = 18'(y) * 18'd41;
    q    = prod[17:12];
    r    = {1'b0, y} - 13'(q) * 13'd100;
    if (r[12]) begin
      qc = q - 6'd1;
      rc = r + 13'd100;
    end else begin
      qc = q;
      rc = r;
    end
    return (y[1:0] == 2'd0) && ((rc != 13'd0) || (qc[1:0] == 2'd0));
  endfunction

  function automatic logic [8:0] year_days(input logic [11:0] y);
    return is_leap(y) ? 9'd366 : 9'd365;
  endfunction

  function automatic logic [4:0] month_days(input logic [11:0] y, input logic [3:0] m);
    logic [3:0] idx;
    idx = m - 4'd1;
    if (m == 4'd2 && is_leap(y))
      return 5'd29;
    else if (m >= 4'd1 && m <= LAST_MONTH)
      return MONTH_LEN[idx];
    else
      return 5'd0;
  endfunction

endpackage

`default_nettype wire

// ===== src/escc_ctrl.sv =====
// ----------------------------------------------------------------------------
// escc_ctrl
// sequencer for the divide, year and month loops and the output slot
// ----------------------------------------------------------------------------
`default_nettype none

module escc_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  input  wire logic                s_tuser,
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  input  wire escc_pkg::dp_status_t status,
  output escc_pkg::dp_op_t         op
);
  import escc_pkg::*;

  state_t     state, state_next;
  logic       out_valid, out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    op         = OP_NONE;
    s_tready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          op         = OP_LOAD;
          state_next = s_tuser ? S_YEAR : S_DIV_DAY;
        end
      end
      S_DIV_DAY: begin
        op         = OP_DIV_DAY;
        state_next = S_INIT_HOUR;
      end
      S_INIT_HOUR: begin
        op         = OP_HOUR_INIT;
        state_next = S_DIV_HOUR;
      end
      S_DIV_HOUR: begin
        op         = OP_DIV_HOUR;
        state_next = S_INIT_MIN;
      end
      S_INIT_MIN: begin
        op         = OP_MIN_INIT;
        state_next = S_DIV_MIN;
      end
      S_DIV_MIN: begin
        op         = OP_DIV_MIN;
        state_next = S_SPLIT_END;
      end
      S_SPLIT_END: begin
        op         = OP_SPLIT_END;
        state_next = S_YEAR;
      end
      S_YEAR: begin
        if (status.year_more) op = OP_YEAR_STEP;
        else state_next = S_MONTH;
      end
      S_MONTH: begin
        if (status.mon_more) op = OP_MON_STEP;
        else state_next = status.req_date ? S_MUL : S_FINISH;
      end
      S_MUL: begin
        op         = OP_MUL;
        state_next = S_SUM;
      end
      S_SUM: begin
        op         = OP_SUM;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid || m_tready) begin
          op         = OP_FINISH;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    if (op == OP_FINISH) out_valid_next = 1'b1;
    else if (m_tready)   out_valid_next = 1'b0;
    else                 out_valid_next = out_valid;
  end

  assign m_tvalid = out_valid;

endmodule

`default_nettype wire

// ===== src/escc_dp.sv =====
// ----------------------------------------------------------------------------
// escc_dp
// reciprocal-multiply split, year/month accumulators and the result register
// ----------------------------------------------------------------------------
`default_nettype none

module escc_dp (
  input  wire logic                          clk,
  input  wire escc_pkg::dp_op_t              op,
  input  wire logic                          s_tuser,
  input  wire logic [escc_pkg::DATA_W-1:0]   s_tdata,
  output escc_pkg::dp_status_t               status,
  output logic [escc_pkg::DATA_W-1:0]        m_tdata
);
  import escc_pkg::*;

  // latched request
  logic        req;
  logic [31:0] secs_in;
  logic [11:0] year_in;
  logic [3:0]  month_in;
  logic [4:0]  day_in;
  logic [4:0]  hour_in;
  logic [5:0]  minute_in;
  logic [5:0]  second_in;

  // working registers
  logic [31:0] work;
  logic [15:0] day_cnt;
  logic [4:0]  hour_r;
  logic [5:0]  minute_r;
  logic [5:0]  second_r;
  logic [11:0] yr;
  logic [3:0]  mon;

  // result register
  logic [31:0] out_seconds;
  logic [11:0] out_year;
  logic [3:0]  out_month;
  logic [4:0]  out_day;
  logic [4:0]  out_hour;
  logic [5:0]  out_minute;
  logic [5:0]  out_second;

  logic [50:0] day_q_prod;
  logic [26:0] hour_q_prod;
  logic [20:0] min_q_prod;
  logic [8:0]  yd;
  logic [11:0] mon_year;
  logic [4:0]  md;
  logic [3:0]  mon_lim;
  logic [48:0] day_prod;
  logic [16:0] hms;

  always_comb begin
    // seconds / 86400 as (seconds / 128) / 675
    day_q_prod  = 51'(work[31:7]) * 51'(DAY_RECIP);
    // remainder / 3600 as (remainder / 16) / 225
    hour_q_prod = 27'(work[16:4]) * 27'(HOUR_RECIP);
    // remainder / 60 as (remainder / 4) / 15
    min_q_prod  = 21'(work[11:2]) * 21'(MIN_RECIP);
    yd       = year_days(yr);
    mon_year = req ? year_in : yr;
    md       = month_days(mon_year, mon);
    mon_lim  = (month_in > MONTH_CAP) ? MONTH_CAP : month_in;
    day_prod = 49'(work) * 49'(SECS_PER_DAY);
    hms      = 17'(hour_in) * 17'(SECS_PER_HR) + 17'(minute_in) * 17'(SECS_PER_MIN)
             + 17'(second_in);
    status.req_date  = req;
    status.year_more = req ? (yr < year_in) : (day_cnt >= 16'(yd));
    status.mon_more  = req ? (mon < mon_lim)
                           : ((mon < LAST_MONTH) && (day_cnt >= 16'(md)));
  end

  always_ff @(posedge clk) begin
    case (op)
      OP_LOAD: begin
        req       <= s_tuser;
        secs_in   <= s_tdata[31:0];
        year_in   <= s_tdata[43:32];
        month_in  <= s_tdata[47:44];
        day_in    <= s_tdata[52:48];
        hour_in   <= s_tdata[57:53];
        minute_in <= s_tdata[63:58];
        second_in <= s_tdata[69:64];
        // day zero wraps to minus one
        work      <= s_tuser ? (32'(s_tdata[52:48]) - 32'd1) : s_tdata[31:0];
        yr        <= EPOCH_YEAR;
        mon       <= 4'd1;
      end
      OP_DIV_DAY: day_cnt <= day_q_prod[50:35];
      OP_HOUR_INIT: work <= work - 32'(day_cnt) * SECS_PER_DAY;
      OP_DIV_HOUR: hour_r <= hour_q_prod[25:21];
      OP_MIN_INIT: work <= work - 32'(hour_r) * 32'(SECS_PER_HR);
      OP_DIV_MIN: minute_r <= min_q_prod[19:14];
      OP_SPLIT_END: second_r <= work[5:0] - 6'(12'(minute_r) * 12'(SECS_PER_MIN));
      OP_YEAR_STEP: begin
        if (req) work <= work + 32'(yd);
        else day_cnt <= day_cnt - 16'(yd);
        yr <= yr + 12'd1;
      end
      OP_MON_STEP: begin
        if (req) work <= work + 32'(md);
        else day_cnt <= day_cnt - 16'(md);
        mon <= mon + 4'd1;
      end
      OP_MUL: work <= day_prod[31:0];
      OP_SUM: work <= work + 32'(hms);
      OP_FINISH: begin
        out_seconds <= req ? work : secs_in;
        out_year    <= req ? year_in : yr;
        out_month   <= req ? month_in : mon;
        out_day     <= req ? day_in : 5'(day_cnt + 16'd1);
        out_hour    <= req ? hour_in : hour_r;
        out_minute  <= req ? minute_in : minute_r;
        out_second  <= req ? second_in : second_r;
      end
      default: ;
    endcase
  end

  assign m_tdata = {2'b00, out_second, out_minute, out_hour, out_day,
                    out_month, out_year, out_seconds};

endmodule

`default_nettype wire

// ===== src/epoch_seconds_calendar_convert.sv =====
// ----------------------------------------------------------------------------
// epoch_seconds_calendar_convert
// converts 32-bit unix seconds to a gregorian date and time and back
//
// channel   dir  tdata bits (low first)                       tuser
// s_*       in   seconds 32, year 12, month 4, day 5,          req_type
//                hour 5, minute 6, second 6, pad 2
// m_*       out  seconds 32, year 12, month 4, day 5,          -
//                hour 5, minute 6, second 6, pad 2
//
// one request at a time; s_tready is high only while the sequencer is idle
// seconds to date: take the request, split it by reciprocal multiplies, step
//   once per year past 1970 and once per month, leave each loop, then load
//   the result
// date to seconds: take the request, step once per year from 1970 to year_in
//   and once per month, multiply by 86400, add the time, load the result
// a held result does not block the next request until it must be replaced
// synchronous reset clears only the sequencer and the result valid flag
// ----------------------------------------------------------------------------
`default_nettype none

`include "epoch_seconds_calendar_convert_macros.svh"

module epoch_seconds_calendar_convert (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         s_tvalid,
  output logic                              s_tready,
  // seconds_in, year_in, month_in, day_in, hour_in, minute_in, second_in
  input  wire logic [escc_pkg::DATA_W-1:0]  s_tdata,
  // req_type
  input  wire logic                         s_tuser,
  output logic                              m_tvalid,
  input  wire logic                         m_tready,
  // seconds_out, year_out, month_out, day_out, hour_out, minute_out, second_out
  output logic [escc_pkg::DATA_W-1:0]       m_tdata
);
  import escc_pkg::*;

  dp_op_t     op;
  dp_status_t status;

  escc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .op       (op)
  );

  escc_dp u_dp (
    .clk     (clk),
    .op      (op),
    .s_tuser (s_tuser),
    .s_tdata (s_tdata),
    .status  (status),
    .m_tdata (m_tdata)
  );

  `ESCC_ASSERT_NEXT(a_busy_after_req, clk, rst, s_tvalid && s_tready, !s_tready, "ready after request")
  `ESCC_ASSERT_NOW(a_load_on_req, clk, rst, op == OP_LOAD, s_tvalid && s_tready, "load without request")
  `ESCC_ASSERT_NEXT(a_finish_valid, clk, rst, op == OP_FINISH, m_tvalid, "result not presented")

endmodule

`default_nettype wire
